FILE: hw/rtl/ams_pkg.sv
// Package for the adjacency matrix store: beat types, codes and fixed field widths.
`timescale 1ns / 1ps
`default_nettype none

package ams_pkg;

  // Fixed field widths.
  localparam int VTX_W   = 6;
  localparam int COUNT_W = 7;
  localparam int TOTAL_W = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_UNDIRECTED   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'd1;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_TEST   = 2'd2,
    MODE_LIST   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [VTX_W-1:0] from_vertex;
    logic [VTX_W-1:0] to_vertex;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic               edge_present;
    logic [VTX_W-1:0]   neighbor;
    logic               neighbor_valid;
    logic [TOTAL_W-1:0] neighbor_total;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_A,
    ST_ROW_B,
    ST_COUNT,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/adjacency_matrix_store.sv
// Top level of the adjacency matrix store: command sequencer, row update and neighbor scan.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a MAX_VERTICES by MAX_VERTICES bit matrix of edges, one
// memory row per source vertex, all cleared at reset by per-row valid bits
// (there is no clearing pass, so commands are taken right after reset).
// A command beat is taken when start is high and busy is low; busy stays
// high until the final result beat of that command is on the result port,
// and a new command may be issued in that same cycle. Result beats are
// shown for exactly one cycle with result_valid high and cannot be held
// off, so the receiver must sample them as they come. Timing is set by the
// row memory, which has one read port and one write port and gives one row
// per cycle with a registered read. Add or remove in undirected mode touch
// a second row as well, unless both vertices are the same. A listing first
// counts the neighbors with a single eight-bit population counter, one byte
// of the row per cycle, and then walks the row one column per cycle, giving
// one result beat for each neighbor and stopping at the last one. Any
// command that names a source vertex, or outside a listing a target vertex,
// at or beyond the configured vertex count gives a single beat with status
// set and leaves the matrix untouched. The configuration registers must be
// written only while the block is idle.
module adjacency_matrix_store #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire ams_pkg::cmd_t                   cmd,
  output logic                                 result_valid,
  output ams_pkg::result_t                     result,
  input  wire logic                            cfg_we,
  input  wire logic [ams_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ams_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import ams_pkg::*;

  localparam int ROW_AW = $clog2(MAX_VERTICES);
  localparam int TOT_W  = $clog2(MAX_VERTICES + 1);
  localparam int CHUNKS = (MAX_VERTICES + 7) / 8;
  localparam int SCAN_W = CHUNKS * 8;
  localparam int CHK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  // Configuration registers.
  logic               undirected_mode;
  logic [COUNT_W-1:0] vertex_count;

  // Sequencer and datapath registers.
  state_t              state;
  state_t              state_next;
  cmd_t                cmd_q;
  logic [MAX_VERTICES-1:0] row_q;
  logic [SCAN_W-1:0]   scan_q;
  logic [CHK_W-1:0]    chunk_q;
  logic [TOT_W-1:0]    total_q;
  logic [TOT_W-1:0]    rem_q;
  logic [ROW_AW-1:0]   col_q;

  // Row memory interface.
  logic                    rd_en;
  logic [ROW_AW-1:0]       rd_addr;
  logic [MAX_VERTICES-1:0] rd_row;
  logic                    wr_en;
  logic [ROW_AW-1:0]       wr_addr;
  logic [MAX_VERTICES-1:0] wr_row;

  // Result staging.
  logic    res_fire;
  result_t res_next;

  // Decoded command facts.
  logic                    accept;
  logic [COUNT_W-1:0]      n_eff;
  logic                    from_ok;
  logic                    to_ok;
  logic                    cmd_bad;
  logic                    mirror;
  logic [ROW_AW-1:0]       from_idx;
  logic [ROW_AW-1:0]       to_idx;
  logic [MAX_VERTICES-1:0] col_mask;
  logic [MAX_VERTICES-1:0] bit_to;
  logic [MAX_VERTICES-1:0] bit_from;
  logic [TOT_W-1:0]        cnt_sum;

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 4'(b[i]);
    end
    return s;
  endfunction

  ams_row_store #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_rows (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_row (rd_row),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_row (wr_row)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      undirected_mode <= 1'b0;
      vertex_count    <= VERTEX_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNDIRECTED:   undirected_mode <= cfg_data[0];
        CFG_VERTEX_COUNT: vertex_count    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // A count above the matrix size acts as the matrix size.
  assign n_eff = (vertex_count > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                         : vertex_count;

  assign from_ok  = COUNT_W'(cmd_q.from_vertex) < n_eff;
  assign to_ok    = COUNT_W'(cmd_q.to_vertex) < n_eff;
  assign cmd_bad  = !from_ok || ((cmd_q.mode != MODE_LIST) && !to_ok);
  assign from_idx = cmd_q.from_vertex[ROW_AW-1:0];
  assign to_idx   = cmd_q.to_vertex[ROW_AW-1:0];
  assign mirror   = undirected_mode && (cmd_q.from_vertex != cmd_q.to_vertex);
  assign bit_to   = MAX_VERTICES'(1) << to_idx;
  assign bit_from = MAX_VERTICES'(1) << from_idx;
  assign cnt_sum  = total_q + TOT_W'(pop8(scan_q[7:0]));

  // Columns at or beyond the vertex count are neither listed nor counted.
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      col_mask[i] = COUNT_W'(i) < n_eff;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_ROW_A;
        end
      end
      ST_ROW_A: begin
        if (cmd_bad || (cmd_q.mode == MODE_TEST)) begin
          state_next = ST_IDLE;
        end else if (cmd_q.mode == MODE_LIST) begin
          state_next = ST_COUNT;
        end else if (mirror) begin
          state_next = ST_ROW_B;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ROW_B: begin
        state_next = ST_IDLE;
      end
      ST_COUNT: begin
        if (chunk_q == '0) begin
          state_next = (cnt_sum == '0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (row_q[0] && (rem_q == TOT_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory control and result beats.
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = from_idx;
    wr_en    = 1'b0;
    wr_addr  = from_idx;
    wr_row   = rd_row;
    res_fire = 1'b0;
    res_next = '0;
    unique case (state)
      ST_IDLE: begin
        rd_en   = accept;
        rd_addr = cmd.from_vertex[ROW_AW-1:0];
      end
      ST_ROW_A: begin
        if (cmd_bad) begin
          res_fire        = 1'b1;
          res_next.status = 1'b1;
          res_next.last   = 1'b1;
        end else begin
          case (cmd_q.mode) inside
            MODE_TEST: begin
              res_fire              = 1'b1;
              res_next.edge_present = rd_row[to_idx];
              res_next.last         = 1'b1;
            end
            MODE_ADD, MODE_REMOVE: begin
              wr_en   = 1'b1;
              wr_addr = from_idx;
              wr_row  = (cmd_q.mode == MODE_ADD) ? (rd_row | bit_to) : (rd_row & ~bit_to);
              if (mirror) begin
                rd_en   = 1'b1;
                rd_addr = to_idx;
              end else begin
                res_fire      = 1'b1;
                res_next.last = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROW_B: begin
        wr_en         = 1'b1;
        wr_addr       = to_idx;
        wr_row        = (cmd_q.mode == MODE_ADD) ? (rd_row | bit_from)
                                                 : (rd_row & ~bit_from);
        res_fire      = 1'b1;
        res_next.last = 1'b1;
      end
      ST_COUNT: begin
        // A vertex with no neighbors gives one empty beat.
        if ((chunk_q == '0) && (cnt_sum == '0)) begin
          res_fire      = 1'b1;
          res_next.last = 1'b1;
        end
      end
      ST_EMIT: begin
        if (row_q[0]) begin
          res_fire                = 1'b1;
          res_next.neighbor       = VTX_W'(col_q);
          res_next.neighbor_valid = 1'b1;
          res_next.neighbor_total = TOTAL_W'(total_q);
          res_next.last           = (rem_q == TOT_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      result <= res_next;
    end
    if (accept) begin
      cmd_q <= cmd;
    end
    unique case (state)
      ST_ROW_A: begin
        row_q   <= rd_row & col_mask;
        scan_q  <= SCAN_W'(rd_row & col_mask);
        total_q <= '0;
        chunk_q <= CHK_W'(CHUNKS - 1);
      end
      ST_COUNT: begin
        scan_q  <= scan_q >> 8;
        total_q <= cnt_sum;
        chunk_q <= chunk_q - CHK_W'(1);
        rem_q   <= cnt_sum;
        col_q   <= '0;
      end
      ST_EMIT: begin
        row_q <= row_q >> 1;
        col_q <= col_q + ROW_AW'(1);
        if (row_q[0]) begin
          rem_q <= rem_q - TOT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // A result beat only follows a cycle in which a command was in progress.
  a_result_follows_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result beat without a command in progress");

  // The final beat of a command always frees the block.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> (state == ST_IDLE))
    else $error("block still busy after the final beat");

  // Beats that are not final only come from the neighbor walk.
  a_more_only_listing: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> (state == ST_EMIT))
    else $error("non-final beat outside a listing");

  // The neighbor walk always has at least one neighbor left to give.
  a_walk_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (rem_q != '0))
    else $error("neighbor walk running with nothing left");

endmodule

`default_nettype wire

FILE: hw/rtl/ams_row_store.sv
// Row memory of the adjacency matrix with per-row valid bits cleared at reset.
`timescale 1ns / 1ps
`default_nettype none

module ams_row_store #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            rd_en,
  input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
  output logic      [MAX_VERTICES-1:0]         rd_row,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
  input  wire logic [MAX_VERTICES-1:0]         wr_row
);

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld;
  logic [MAX_VERTICES-1:0] rd_q;
  logic                    hit_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // A row that was never written reads as all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_q <= row_vld[rd_addr];
      end
    end
  end

  assign rd_row = hit_q ? rd_q : '0;

endmodule

`default_nettype wire

FILE: verif/adjacency_matrix_store_test.sv
// Self-checking testbench for the adjacency matrix store: directed and random command traffic.
`timescale 1ns / 1ps

// The bench keeps its own copy of the edge matrix and of the two
// configuration registers. When a command beat is accepted, it works out
// every result beat that the command should produce and appends them to a
// queue. A checker process takes each result beat as it is shown and
// compares it, field by field, with the oldest beat in that queue.
//
// Commands go out at the falling clock edge and are accepted at the first
// rising edge where busy is low. Outputs are read at the rising edge,
// before the block's own registers update in that time step.
module adjacency_matrix_store_test;
  import ams_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  cmd_t                  cmd_beat;
  logic                  result_valid;
  result_t               result_beat;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  adjacency_matrix_store dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd_beat),
    .result_valid (result_valid),
    .result       (result_beat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Local copy of the block's state: one 64-bit row per source vertex, plus
  // the two configuration registers as last written.
  logic [63:0]        edge_mirror [64];
  logic               mirror_undirected;
  logic [COUNT_W-1:0] mirror_count;

  // Result beats still owed by the block, oldest first.
  result_t pending_beats [$];
  result_t expected_beat;

  int failure_count;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block stops answering. The slowest legal run is
  // well under half a millisecond, so this leaves a wide margin.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic note_failure(string why, result_t want, result_t got);
    failure_count++;
    if (failure_count <= 10) begin
      $display("%0t: %s: expected st=%0d ep=%0d nb=%0d nv=%0d tot=%0d last=%0d", $realtime,
               why, want.status, want.edge_present, want.neighbor, want.neighbor_valid,
               want.neighbor_total, want.last);
      $display("%0t:   actual st=%0d ep=%0d nb=%0d nv=%0d tot=%0d last=%0d", $realtime,
               got.status, got.edge_present, got.neighbor, got.neighbor_valid,
               got.neighbor_total, got.last);
    end
  endtask

  // Applies one accepted command to the local matrix and queues the result
  // beats it must produce.
  function automatic void predict_command(cmd_t c);
    int unsigned active;
    logic [63:0] row;
    logic [63:0] col_mask;
    int          total;
    int          seen;
    result_t     beat;

    // Counts above the matrix size behave as the full matrix.
    active = (mirror_count > 64) ? 64 : mirror_count;
    beat = '0;
    beat.last = 1'b1;

    // Any vertex outside the active range: a single beat with status set,
    // and the matrix stays as it was. A listing ignores its to field.
    if (c.from_vertex >= active || (c.mode != MODE_LIST && c.to_vertex >= active)) begin
      beat.status = 1'b1;
      pending_beats.push_back(beat);
      return;
    end

    case (c.mode)
      MODE_ADD: begin
        // A self loop in undirected mode simply sets the same bit twice.
        edge_mirror[c.from_vertex][c.to_vertex] = 1'b1;
        if (mirror_undirected) edge_mirror[c.to_vertex][c.from_vertex] = 1'b1;
        pending_beats.push_back(beat);
      end
      MODE_REMOVE: begin
        edge_mirror[c.from_vertex][c.to_vertex] = 1'b0;
        if (mirror_undirected) edge_mirror[c.to_vertex][c.from_vertex] = 1'b0;
        pending_beats.push_back(beat);
      end
      MODE_TEST: begin
        beat.edge_present = edge_mirror[c.from_vertex][c.to_vertex];
        pending_beats.push_back(beat);
      end
      default: begin
        // Edges left in columns beyond the current count stay in the row but
        // are neither listed nor counted.
        col_mask = (active >= 64) ? '1 : ((64'd1 << active) - 64'd1);
        row = edge_mirror[c.from_vertex] & col_mask;
        total = 0;
        for (int i = 0; i < 64; i++) if (row[i]) total++;
        if (total == 0) begin
          // No neighbors: one beat that carries no vertex.
          pending_beats.push_back(beat);
        end else begin
          seen = 0;
          for (int i = 0; i < 64; i++) begin
            if (row[i]) begin
              seen++;
              beat.neighbor       = i[VTX_W-1:0];
              beat.neighbor_valid = 1'b1;
              beat.neighbor_total = total[TOTAL_W-1:0];
              beat.last           = (seen == total);
              pending_beats.push_back(beat);
            end
          end
        end
      end
    endcase
  endfunction

  // Result checker. Every beat shown by the block must match the oldest
  // expectation; a beat with nothing waiting is a failure on its own.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_beats.size() == 0) begin
        note_failure("result beat with nothing expected", '0, result_beat);
      end else begin
        expected_beat = pending_beats.pop_front();
        if (result_beat.status !== expected_beat.status ||
            result_beat.edge_present !== expected_beat.edge_present ||
            result_beat.neighbor !== expected_beat.neighbor ||
            result_beat.neighbor_valid !== expected_beat.neighbor_valid ||
            result_beat.neighbor_total !== expected_beat.neighbor_total ||
            result_beat.last !== expected_beat.last) begin
          note_failure("result mismatch", expected_beat, result_beat);
        end
      end
    end
  end

  // Sends one command. Entered and left at a falling edge. Start is left
  // high on return so that a following command with no gap keeps it high;
  // it is only lowered when a gap is drawn or the bench goes idle.
  task automatic issue_command(mode_t m, int unsigned from_v, int unsigned to_v);
    cmd_t        c;
    int unsigned gap;

    c.mode        = m;
    c.from_vertex = from_v[VTX_W-1:0];
    c.to_vertex   = to_v[VTX_W-1:0];
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    cmd_beat <= c;
    do @(posedge clk); while (busy);
    predict_command(c);
    @(negedge clk);
  endtask

  // Drops start and waits until every owed beat has come back. Every
  // command produces at least one beat, so the block is idle after that.
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending_beats.size() != 0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_UNDIRECTED) mirror_undirected = data[0];
    else mirror_count = data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Writes both registers. Only bit 0 of the mode register counts, so the
  // upper data bits get random junk.
  task automatic set_config(bit undirected, int unsigned count);
    logic [CFG_DATA_W-1:0] mode_data;

    mode_data    = $urandom_range(0, 127);
    mode_data[0] = undirected;
    write_register(CFG_UNDIRECTED, mode_data);
    write_register(CFG_VERTEX_COUNT, count[CFG_DATA_W-1:0]);
  endtask

  // Mostly in-range vertices, with a bias toward a few low labels so that
  // rows fill up enough for listings to get long.
  function automatic int unsigned pick_vertex(int unsigned active);
    if (active > 0 && $urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, (active < 8 ? active : 8) - 1);
      if ($urandom_range(0, 9) == 0) return active - 1;
      return $urandom_range(0, active - 1);
    end
    return $urandom_range(0, 63);
  endfunction

  // Directed mode at the full count: corners of the matrix, a self loop, a
  // test of an absent edge, an empty listing and a removal.
  task automatic test_directed_edges();
    issue_command(MODE_ADD, 0, 63);
    issue_command(MODE_ADD, 0, 0);
    issue_command(MODE_ADD, 63, 0);
    issue_command(MODE_TEST, 0, 63);
    issue_command(MODE_TEST, 63, 63);
    issue_command(MODE_LIST, 0, 0);
    issue_command(MODE_LIST, 5, 17);
    issue_command(MODE_REMOVE, 63, 0);
    issue_command(MODE_TEST, 63, 0);
  endtask

  // Undirected mode: the mirrored bit follows every add and remove, and a
  // self loop touches only one bit.
  task automatic test_undirected_edges();
    wait_idle();
    set_config(1'b1, 64);
    issue_command(MODE_ADD, 10, 20);
    issue_command(MODE_TEST, 20, 10);
    issue_command(MODE_ADD, 7, 7);
    issue_command(MODE_LIST, 7, 0);
    issue_command(MODE_REMOVE, 20, 10);
    issue_command(MODE_TEST, 10, 20);
    issue_command(MODE_LIST, 20, 63);
  endtask

  // Vertex count limits: out-of-range from and to, a listing whose row still
  // holds an edge in a column beyond the count, a zero count and a count
  // above the matrix size.
  task automatic test_vertex_limits();
    wait_idle();
    set_config(1'b0, 8);
    issue_command(MODE_ADD, 3, 9);
    issue_command(MODE_TEST, 9, 0);
    issue_command(MODE_LIST, 8, 0);
    issue_command(MODE_LIST, 0, 63);
    issue_command(MODE_TEST, 0, 63);
    wait_idle();
    set_config(1'b0, 0);
    issue_command(MODE_TEST, 0, 0);
    wait_idle();
    set_config(1'b1, 127);
    issue_command(MODE_LIST, 0, 0);
  endtask

  task automatic run_random_phase(bit undirected, int unsigned count, int unsigned items);
    int unsigned active;
    int unsigned pick;
    mode_t       m;

    wait_idle();
    set_config(undirected, count);
    active = (count > 64) ? 64 : count;
    for (int k = 0; k < items; k++) begin
      // Now and then run a stretch of commands back to back.
      if (k % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) m = MODE_ADD;
      else if (pick < 50) m = MODE_REMOVE;
      else if (pick < 75) m = MODE_TEST;
      else m = MODE_LIST;
      issue_command(m, pick_vertex(active), pick_vertex(active));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(1'b0, 64, 70);
    run_random_phase(1'b1, 64, 70);
    run_random_phase(1'b0, 5, 40);
    run_random_phase(1'b1, 2, 30);
    run_random_phase(1'b1, $urandom_range(1, 64), 30);
    run_random_phase(1'b0, 127, 40);
    run_random_phase(1'b0, 0, 10);
    run_random_phase(1'b0, 1, 10);
  endtask

  initial begin
    int guard;

    rst       = 1'b1;
    start     = 1'b0;
    cmd_beat  = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_UNDIRECTED;
    cfg_data  = '0;
    failure_count     = 0;
    no_idle           = 1'b0;
    mirror_undirected = 1'b0;
    mirror_count      = VERTEX_COUNT_RESET;
    for (int r = 0; r < 64; r++) edge_mirror[r] = '0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_edges();
    test_undirected_edges();
    test_vertex_limits();
    test_random_traffic();

    // Drain: let the owed beats arrive, then watch for strays for a bit
    // longer than the slowest listing.
    start <= 1'b0;
    guard = 0;
    while (pending_beats.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (100) @(negedge clk);
    if (pending_beats.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $realtime, pending_beats.size());
      failure_count += pending_beats.size();
    end

    if (failure_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ams_pkg.sv
hw/rtl/ams_row_store.sv
hw/rtl/adjacency_matrix_store.sv
verif/adjacency_matrix_store_test.sv
